FILE: rtl/vsmm_pkg.sv
// Package with the word types, fixed widths and controller states of the moving mean unit.
package vsmm_pkg;

    localparam int SAMPLE_BITS   = 32;
    localparam int WIN_LEN_BITS  = 9;
    localparam int WIN_LEN_RESET = 16;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          sample_valid;
        logic                          sample_missing;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mean;
        logic                          mean_present;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_OUTPUT
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic update;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/vsmm_div.sv
// Radix-2 restoring divider of a signed sum by an unsigned count, one quotient bit per cycle.
module vsmm_div #(
    parameter int SUM_W = 40,
    parameter int CNT_W = 9
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [SUM_W-1:0]               dividend,
    input  logic        [CNT_W-1:0]               divisor,
    output logic                                  busy,
    output logic signed [vsmm_pkg::SAMPLE_BITS-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  quot_reg, quot_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvsr_reg, dvsr_next;
    logic              neg_reg, neg_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;
    logic [SUM_W-1:0]  mag;
    logic [vsmm_pkg::SAMPLE_BITS-1:0] q_low;

    always_comb
    begin
        mag   = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
        trial = {rem_reg, quot_reg[SUM_W-1]};
        diff  = trial - {1'b0, dvsr_reg};
        ge    = (trial >= {1'b0, dvsr_reg});
    end

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        neg_next  = neg_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quot_next = mag;
            rem_next  = '0;
            dvsr_next = divisor;
            neg_next  = dividend[SUM_W-1];
            step_next = STEP_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[SUM_W-2:0], ge};
            rem_next  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        neg_reg  <= neg_next;
    end

    // The mean always lies within the sample range, so the low bits carry it all.
    assign q_low    = quot_reg[vsmm_pkg::SAMPLE_BITS-1:0];
    assign quotient = neg_reg ? signed'(~q_low + 1'b1) : signed'(q_low);
    assign busy     = busy_reg;

endmodule

FILE: rtl/vsmm_dp.sv
// Datapath of the moving mean unit: history memory, running sum, counters, divider and output register.
module vsmm_dp #(
    parameter int MAX_WINDOW = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  vsmm_pkg::ctrl_cmd_t                  cmd,
    output vsmm_pkg::dp_status_t                 status,
    input  vsmm_pkg::in_word_t                   in_data,
    input  logic                                 cfg_wr_en,
    input  logic [vsmm_pkg::WIN_LEN_BITS-1:0]    cfg_wr_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output vsmm_pkg::out_word_t                  out_data
);

    localparam int SB     = vsmm_pkg::SAMPLE_BITS;
    localparam int IDX_W  = $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SB + IDX_W;
    localparam int EXT_W  = (CNT_W > vsmm_pkg::WIN_LEN_BITS) ? CNT_W : vsmm_pkg::WIN_LEN_BITS;
    localparam int WIN_RST = (vsmm_pkg::WIN_LEN_RESET > MAX_WINDOW) ?
                             MAX_WINDOW : vsmm_pkg::WIN_LEN_RESET;

    logic [SB-1:0] hist_mem [MAX_WINDOW];

    logic [CNT_W-1:0]        win_reg, win_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        slot_reg, slot_next;
    logic [SB-1:0]           rd_reg;
    logic [SB-1:0]           smp_reg;
    logic                    take_reg;
    logic                    present_reg;
    logic                    out_valid_reg, out_valid_next;
    vsmm_pkg::out_word_t     out_data_reg;

    logic [EXT_W-1:0]        wl_ext;
    logic [CNT_W-1:0]        win_eff;
    logic                    full;
    logic [CNT_W-1:0]        slot_inc;
    logic signed [SUM_W-1:0] smp_ext;
    logic signed [SUM_W-1:0] old_ext;
    logic                    div_busy;
    logic signed [SB-1:0]    quot;

    vsmm_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.accept),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .busy     (div_busy),
        .quotient (quot)
    );

    // A window length of zero acts as one; lengths beyond the memory saturate.
    always_comb
    begin
        wl_ext = EXT_W'(cfg_wr_data);
        if (wl_ext == '0)
        begin
            win_eff = CNT_W'(1);
        end
        else if (wl_ext > EXT_W'(MAX_WINDOW))
        begin
            win_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            win_eff = wl_ext[CNT_W-1:0];
        end
    end

    always_comb
    begin
        full     = (count_reg >= win_reg);
        slot_inc = CNT_W'(slot_reg) + 1'b1;
        smp_ext  = {{(SUM_W-SB){smp_reg[SB-1]}}, smp_reg};
        old_ext  = full ? {{(SUM_W-SB){rd_reg[SB-1]}}, rd_reg} : '0;

        win_next   = win_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        slot_next  = slot_reg;
        if (cfg_wr_en)
        begin
            win_next   = win_eff;
            sum_next   = '0;
            count_next = '0;
            slot_next  = '0;
        end
        else if (cmd.update && take_reg)
        begin
            sum_next = sum_reg - old_ext + smp_ext;
            if (!full)
            begin
                count_next = count_reg + 1'b1;
            end
            slot_next = (slot_inc >= win_reg) ? '0 : slot_inc[IDX_W-1:0];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= CNT_W'(WIN_RST);
            sum_reg       <= '0;
            count_reg     <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            win_reg       <= win_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_reg      <= hist_mem[slot_reg];
            smp_reg     <= in_data.sample;
            take_reg    <= in_data.sample_valid && !in_data.sample_missing;
            present_reg <= (count_reg != '0);
        end
        if (cmd.update && take_reg)
        begin
            hist_mem[slot_reg] <= smp_reg;
        end
        if (cmd.load_out)
        begin
            out_data_reg.mean         <= present_reg ? quot : '0;
            out_data_reg.mean_present <= present_reg;
        end
    end

    assign status.div_busy = div_busy;
    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

FILE: rtl/vsmm_ctrl.sv
// Controller state machine of the moving mean unit.
module vsmm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  vsmm_pkg::dp_status_t  status,
    output vsmm_pkg::ctrl_cmd_t   cmd
);

    vsmm_pkg::ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vsmm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = vsmm_pkg::ST_UPDATE;
                end
            end
            vsmm_pkg::ST_UPDATE:
            begin
                state_next = vsmm_pkg::ST_DIVIDE;
            end
            vsmm_pkg::ST_DIVIDE:
            begin
                if (!status.div_busy)
                begin
                    state_next = vsmm_pkg::ST_OUTPUT;
                end
            end
            vsmm_pkg::ST_OUTPUT:
            begin
                if (status.out_free)
                begin
                    state_next = vsmm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vsmm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall     = 1'b1;
        cmd.accept   = 1'b0;
        cmd.update   = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            vsmm_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            vsmm_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            vsmm_pkg::ST_DIVIDE:
            begin
            end
            vsmm_pkg::ST_OUTPUT:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vsmm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/valid_sample_moving_mean_unit.sv
// Top level of the moving mean unit over valid, non-missing samples.
//
//   Channel   Signals                           Direction  Word
//   in        in_valid, in_stall, in_data       into unit  sample and its two flags
//   out       out_valid, out_stall, out_data    out of it  mean and its presence flag
//   cfg       cfg_wr_en, cfg_wr_data            into unit  window length, no read-back
//
// On acceptance of each input word the radix-2 divider, which produces one quotient bit a
// cycle, starts on the running sum held before it while the history is updated; its
// result is then loaded into the output register. No new word is taken before that, and
// the input side opens again in the cycle after the result has moved into the output
// register. A waiting result holds back the input side only once the next result is
// finished. Reset is asynchronous and active low; it sets the window length to 16 (or
// MAX_WINDOW if smaller) and empties the history. A stall on the output holds the result
// in place, and the unit holds off the next word while a finished result cannot be loaded.
//
// For every word the mean of the samples held before it is reported first, truncated
// toward zero. Only a word that is valid and not missing then enters the history,
// displacing the oldest sample once the window is full. Writing the window length
// clears the history, the running sum and the write position.
module valid_sample_moving_mean_unit #(
    parameter int MAX_WINDOW = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  vsmm_pkg::in_word_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output vsmm_pkg::out_word_t               out_data,
    input  logic                              cfg_wr_en,
    input  logic [vsmm_pkg::WIN_LEN_BITS-1:0] cfg_wr_data
);

    // Commands from the controller and status back from the datapath.
    vsmm_pkg::ctrl_cmd_t  cmd;
    vsmm_pkg::dp_status_t status;

    vsmm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    vsmm_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule
